/* hw/rtl/rabc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rabc_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int POS_W     = $clog2(MAX_DIM);
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DEPTH = 4;

  localparam logic [DIM_W-1:0]     DIM_RESET        = DIM_W'(64);
  localparam logic [15:0]          KEY_COLOUR       = 16'h07E0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic RESULT_PIXEL = 1'b0;
  localparam logic RESULT_BOX   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic              box_empty;
    logic [DIM_W-1:0]  box_height;
    logic [DIM_W-1:0]  box_width;
    logic [POS_W-1:0]  box_top;
    logic [POS_W-1:0]  box_left;
    logic [7:0]        opacity;
    logic [15:0]       pixel;
  } result_t;

  // Largest position on a line or in a frame for a configured size, with a
  // size of zero taken as one and anything above the maximum saturated.
  function automatic logic [POS_W-1:0] last_pos(input logic [DIM_W-1:0] dim);
    logic [POS_W-1:0] r;
    if (dim == '0) begin
      r = '0;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      r = POS_W'(MAX_DIM - 1);
    end else begin
      r = POS_W'(dim - DIM_W'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/rabc_result_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module rabc_result_fifo
  import rabc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr_en,
  input  wire logic    wr_two,
  input  wire result_t wr_a,
  input  wire result_t wr_b,
  output logic         has_room,
  output logic         rd_valid,
  output result_t      rd_data,
  input  wire logic    rd_ready
);

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t           mem [OUT_DEPTH];
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  tail;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  push_n;
  logic              pop;

  assign pop      = rd_valid && rd_ready;
  assign push_n   = wr_en ? (wr_two ? CNT_W'(2) : CNT_W'(1)) : '0;
  assign count_next = count + push_n - (pop ? CNT_W'(1) : '0);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[head];
  assign has_room = (count <= CNT_W'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      if (wr_en) begin
        tail <= tail + push_n[PTR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= wr_a;
      if (wr_two) begin
        mem[tail + PTR_W'(1)] <= wr_b;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(OUT_DEPTH))
    else $error("result queue overfilled");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (count <= CNT_W'(OUT_DEPTH - 2)))
    else $error("result pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !pop) |=> (count == $past(count) + $past(push_n)))
    else $error("result queue fill count wrong");
`endif

endmodule

`default_nettype wire

/* hw/rtl/rgb565_alpha_bbox_converter.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   RGBA8888 pixel
// m_axis    out  m_axis_tvalid / m_axis_tready   pixel or box word
// cfg       in   cfg_valid / cfg_ready           register index, size
//
// One pixel is accepted per cycle while the result queue has room; its results are in the queue the cycle after.
// The last pixel of a frame yields two words (pixel, then box), so the
// input can stall at the end of a frame even when the output flows.
// The four-entry result queue sets this: input is taken while two places
// are free. Reset is synchronous and restores the 64 by 64 frame size.
// The configuration channel is always ready.

module rgb565_alpha_bbox_converter
  import rabc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], opacity [31:24]
  input  wire logic [31:0]          s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // pixel_565 [15:0], opacity_out [23:16], box_left [33:24], box_top [43:34],
  // box_width [54:44], box_height [65:55], box_empty [66], zeros above
  output logic [71:0]               m_axis_tdata,
  // result_kind
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [POS_W-1:0] column_count;
  logic [POS_W-1:0] line_count;
  logic [POS_W-1:0] min_column;
  logic [POS_W-1:0] max_column;
  logic [POS_W-1:0] min_line;
  logic [POS_W-1:0] max_line;
  logic             any_visible;

  logic [POS_W-1:0] min_column_next;
  logic [POS_W-1:0] max_column_next;
  logic [POS_W-1:0] min_line_next;
  logic [POS_W-1:0] max_line_next;
  logic             any_visible_next;

  logic       accept;
  logic       visible;
  logic       line_end;
  logic       frame_end;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] opacity;
  logic       fifo_room;

  result_t pixel_res;
  result_t box_res;
  result_t out_res;

  assign red     = s_axis_tdata[7:0];
  assign green   = s_axis_tdata[15:8];
  assign blue    = s_axis_tdata[23:16];
  assign opacity = s_axis_tdata[31:24];

  assign s_axis_tready = fifo_room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign visible   = (opacity != 8'd0);
  assign line_end  = (column_count >= last_pos(frame_width));
  assign frame_end = line_end && (line_count >= last_pos(frame_height));

  always_comb begin
    min_column_next  = min_column;
    max_column_next  = max_column;
    min_line_next    = min_line;
    max_line_next    = max_line;
    if (visible) begin
      if (!any_visible || column_count < min_column) begin
        min_column_next = column_count;
      end
      if (!any_visible || column_count > max_column) begin
        max_column_next = column_count;
      end
      if (!any_visible || line_count < min_line) begin
        min_line_next = line_count;
      end
      if (!any_visible || line_count > max_line) begin
        max_line_next = line_count;
      end
    end
    any_visible_next = any_visible || visible;
  end

  always_comb begin
    pixel_res         = '0;
    pixel_res.kind    = RESULT_PIXEL;
    pixel_res.opacity = opacity;
    pixel_res.pixel   = visible ? {red[7:3], green[7:2], blue[7:3]} : KEY_COLOUR;

    box_res      = '0;
    box_res.kind = RESULT_BOX;
    box_res.last = 1'b1;
    if (any_visible_next) begin
      box_res.box_left   = min_column_next;
      box_res.box_top    = min_line_next;
      box_res.box_width  = DIM_W'(max_column_next) - DIM_W'(min_column_next)
                           + DIM_W'(1);
      box_res.box_height = DIM_W'(max_line_next) - DIM_W'(min_line_next)
                           + DIM_W'(1);
    end else begin
      box_res.box_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAME_WIDTH) begin
        frame_width <= cfg_data;
      end else if (cfg_index == CFG_FRAME_HEIGHT) begin
        frame_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count   <= '0;
      min_column   <= '1;
      max_column   <= '0;
      min_line     <= '1;
      max_line     <= '0;
      any_visible  <= 1'b0;
    end else if (accept) begin
      if (frame_end) begin
        column_count <= '0;
        line_count   <= '0;
        min_column   <= '1;
        max_column   <= '0;
        min_line     <= '1;
        max_line     <= '0;
        any_visible  <= 1'b0;
      end else begin
        min_column  <= min_column_next;
        max_column  <= max_column_next;
        min_line    <= min_line_next;
        max_line    <= max_line_next;
        any_visible <= any_visible_next;
        if (line_end) begin
          column_count <= '0;
          line_count   <= line_count + POS_W'(1);
        end else begin
          column_count <= column_count + POS_W'(1);
        end
      end
    end
  end

  rabc_result_fifo u_result_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_two   (frame_end),
    .wr_a     (pixel_res),
    .wr_b     (box_res),
    .has_room (fifo_room),
    .rd_valid (m_axis_tvalid),
    .rd_data  (out_res),
    .rd_ready (m_axis_tready)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;
  assign m_axis_tdata = {5'b0, out_res.box_empty, out_res.box_height, out_res.box_width,
                         out_res.box_top, out_res.box_left, out_res.opacity,
                         out_res.pixel};

`ifndef SYNTHESIS
  a_clear_box_when_none: assert property (@(posedge clk) disable iff (rst)
    !any_visible |-> (min_column == '1 && max_column == '0
                      && min_line == '1 && max_line == '0))
    else $error("box state not clear while no pixel is visible");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_visible |-> (min_column <= max_column && min_line <= max_line))
    else $error("box bounds out of order");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted pixel produced no result word");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> (column_count == '0 && line_count == '0 && !any_visible))
    else $error("frame state not restarted after frame end");
`endif

endmodule

`default_nettype wire

/* test/tb_rgb565_alpha_bbox_converter.sv */
`timescale 1ns / 1ps

module tb_rgb565_alpha_bbox_converter;
  import rabc_pkg::*;

  localparam logic ROW_PIXEL = 1'b0;
  localparam logic ROW_CFG   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_PIXELS = 830;
  localparam int HOLD_CYCLES   = 100;
  localparam int GAP_MAX       = 13;
  localparam int SCRIPT_LEN    = 26;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     value;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           opacity;
    logic [15:0]          lit_pixel;
  } step_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [71:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] line_pos;
  logic [POS_W-1:0] min_col;
  logic [POS_W-1:0] max_col;
  logic [POS_W-1:0] min_line;
  logic [POS_W-1:0] max_line;
  logic             seen_visible;
  result_t          awaited_words[$];

  int        errors = 0;
  int        cycles = 0;
  bit        hold_off_req = 1'b0;
  bit        src_calm = 1'b0;
  step_row_t script [SCRIPT_LEN];

  rgb565_alpha_bbox_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int eff_dim(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > DIM_W'(MAX_DIM)) begin
      return MAX_DIM;
    end
    return int'(v);
  endfunction

  function automatic step_row_t pix(input logic [7:0] r, g, b, a, input logic [15:0] lit);
    step_row_t row;
    row = '0;
    row.is_cfg = ROW_PIXEL;
    row.red = r;
    row.green = g;
    row.blue = b;
    row.opacity = a;
    row.lit_pixel = lit;
    return row;
  endfunction

  function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DIM_W-1:0] value);
    step_row_t row;
    row = '0;
    row.is_cfg = ROW_CFG;
    row.index = idx;
    row.value = value;
    return row;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return '0;
    end
    if (roll == 1) begin
      return DIM_W'($urandom_range(MAX_DIM, 2047));
    end
    return DIM_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [7:0] pick_opacity();
    int roll;
    roll = $urandom_range(0, 5);
    if (roll < 2) begin
      return 8'h00;
    end
    if (roll == 2) begin
      return 8'hFF;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic restart_frame();
    col_pos = '0;
    line_pos = '0;
    min_col = '1;
    max_col = '0;
    min_line = '1;
    max_line = '0;
    seen_visible = 1'b0;
  endtask

  task automatic await_word(input result_t word);
    awaited_words.insert(awaited_words.size(), word);
  endtask

  task automatic convert_pixel(input logic [7:0] r, g, b, a);
    result_t word;
    result_t box;
    word = '0;
    word.kind = RESULT_PIXEL;
    word.pixel = (a == 8'h00) ? KEY_COLOUR : {r[7:3], g[7:2], b[7:3]};
    word.opacity = a;
    await_word(word);
    if (a != 8'h00) begin
      if (!seen_visible || col_pos < min_col) min_col = col_pos;
      if (!seen_visible || col_pos > max_col) max_col = col_pos;
      if (!seen_visible || line_pos < min_line) min_line = line_pos;
      if (!seen_visible || line_pos > max_line) max_line = line_pos;
      seen_visible = 1'b1;
    end
    if (int'(col_pos) >= eff_dim(width_reg) - 1) begin
      col_pos = '0;
      if (int'(line_pos) >= eff_dim(height_reg) - 1) begin
        box = '0;
        box.kind = RESULT_BOX;
        box.last = 1'b1;
        if (seen_visible) begin
          box.box_left = min_col;
          box.box_top = min_line;
          box.box_width = DIM_W'(max_col) - DIM_W'(min_col) + DIM_W'(1);
          box.box_height = DIM_W'(max_line) - DIM_W'(min_line) + DIM_W'(1);
        end else begin
          box.box_empty = 1'b1;
        end
        await_word(box);
        restart_frame();
      end else begin
        line_pos = line_pos + POS_W'(1);
      end
    end else begin
      col_pos = col_pos + POS_W'(1);
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, a, input bit has_lit,
                            input logic [15:0] lit);
    int      gap;
    int      slot;
    result_t word;
    cfg_valid <= 1'b0;
    gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {a, b, g, r};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    slot = awaited_words.size();
    convert_pixel(r, g, b, a);
    if (has_lit) begin
      word = awaited_words[slot];
      word.pixel = lit;
      awaited_words[slot] = word;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH: width_reg = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic note_error(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("mismatch in %s at cycle %0d: expected %h, got %h", what, cycles, want, got);
    end
  endtask

  task automatic check_word();
    result_t want;
    result_t got;
    got = '0;
    got.kind = m_axis_tuser;
    got.last = m_axis_tlast;
    got.pixel = m_axis_tdata[15:0];
    got.opacity = m_axis_tdata[23:16];
    got.box_left = m_axis_tdata[33:24];
    got.box_top = m_axis_tdata[43:34];
    got.box_width = m_axis_tdata[54:44];
    got.box_height = m_axis_tdata[65:55];
    got.box_empty = m_axis_tdata[66];
    if (awaited_words.size() == 0) begin
      note_error("word with none awaited", '0, got);
    end else begin
      want = awaited_words.pop_front();
      if (got !== want) note_error("result word", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_word();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : word_sink
    int gap;
    int taken;
    bit sink_calm;
    taken = 0;
    sink_calm = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) sink_calm = ($urandom_range(0, 3) == 0);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin : pixel_source
    int  n;
    int  sent;
    bit  held;
    width_reg = DIM_RESET;
    height_reg = DIM_RESET;
    restart_frame();
    sent = 0;
    held = 1'b0;
    script = '{
      pix(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF),
      pix(8'h00, 8'h00, 8'h00, 8'h01, 16'h0000),
      pix(8'h12, 8'h34, 8'h56, 8'h00, KEY_COLOUR),
      pix(8'hF8, 8'h00, 8'h00, 8'h80, 16'hF800),
      pix(8'h00, 8'hFC, 8'h00, 8'h7F, 16'h07E0),
      pix(8'h00, 8'h00, 8'hF8, 8'hFE, 16'h001F),
      pix(8'h07, 8'h03, 8'h07, 8'h40, 16'h0000),
      reg_row(CFG_FRAME_WIDTH, DIM_W'(3)),
      reg_row(CFG_FRAME_HEIGHT, DIM_W'(2)),
      pix(8'hAA, 8'h55, 8'hAA, 8'h00, KEY_COLOUR),
      pix(8'h55, 8'hAA, 8'h55, 8'h00, KEY_COLOUR),
      pix(8'h9C, 8'h5A, 8'h3E, 8'h20, 16'h9AC7),
      pix(8'h0F, 8'hF0, 8'h0F, 8'h00, KEY_COLOUR),
      pix(8'hFF, 8'hFF, 8'hFF, 8'h00, KEY_COLOUR),
      pix(8'h00, 8'h00, 8'h00, 8'h00, KEY_COLOUR),
      pix(8'h80, 8'h80, 8'h80, 8'h00, KEY_COLOUR),
      pix(8'h01, 8'h02, 8'h03, 8'h00, KEY_COLOUR),
      pix(8'hFE, 8'hFD, 8'hFC, 8'h00, KEY_COLOUR),
      pix(8'h7F, 8'h7F, 8'h7F, 8'h00, KEY_COLOUR),
      reg_row(CFG_FRAME_WIDTH, DIM_W'(0)),
      reg_row(CFG_FRAME_HEIGHT, DIM_W'(0)),
      pix(8'h33, 8'h66, 8'h99, 8'h00, KEY_COLOUR),
      pix(8'hFF, 8'h00, 8'hFF, 8'hFF, 16'hF81F),
      reg_row(CFG_SPARE_2, DIM_W'(2047)),
      reg_row(CFG_SPARE_3, DIM_W'(5)),
      pix(8'h08, 8'h04, 8'h08, 8'h01, 16'h0821)
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg == ROW_CFG) begin
        wait_idle();
        write_reg(script[i].index, script[i].value);
      end else begin
        send_pixel(script[i].red, script[i].green, script[i].blue, script[i].opacity,
                   1'b1, script[i].lit_pixel);
      end
    end

    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      src_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_WIDTH, pick_dim());
      if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_HEIGHT, pick_dim());
      if ($urandom_range(0, 7) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                  DIM_W'($urandom_range(0, 2047)));
      end
      n = eff_dim(width_reg) * eff_dim(height_reg) * $urandom_range(1, 3);
      if (n > 64) n = $urandom_range(1, 64);
      if ($urandom_range(0, 5) == 0) n += $urandom_range(1, 5);
      if (!held && sent >= 300) begin
        // The output is held off while pixels keep coming, so the block backs up.
        held = 1'b1;
        hold_off_req = 1'b1;
        src_calm = 1'b1;
        n = 48;
      end
      for (int i = 0; i < n; i++) begin
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_opacity(), 1'b0, '0);
      end
      sent += n;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && awaited_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rabc_pkg.sv
hw/rtl/rabc_result_fifo.sv
hw/rtl/rgb565_alpha_bbox_converter.sv
test/tb_rgb565_alpha_bbox_converter.sv
